/* rtl/core/mtflru_pkg.sv */
package mtflru_pkg;

    // Field widths of one lookup and one result.
    localparam int KEY_HIGH_W = 16;
    localparam int KEY_LOW_W  = 64;
    localparam int HANDLE_W   = 16;
    localparam int CAP_W      = 4;

    // Capacity in force after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

    // One cached entry: the 80-bit key id and its handle.
    typedef struct packed {
        logic [KEY_HIGH_W-1:0] key_high;
        logic [KEY_LOW_W-1:0]  key_low;
        logic [HANDLE_W-1:0]   handle;
    } entry_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic cmp_en;  // capture the compare result of this cell
        logic load;    // take the entry offered by the neighbor
        logic live;    // the cell holds one of the live entries
    } cell_ctrl_t;

endpackage

/* rtl/core/mtflru_if.sv */
// Lookup channel: one item is a key id and the handle a fetch would give.
interface mtflru_lookup_if
    import mtflru_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KEY_HIGH_W-1:0] key_high;
    logic [KEY_LOW_W-1:0]  key_low;
    logic [HANDLE_W-1:0]   fetched_handle;

    modport source (output valid, output key_high, output key_low,
                    output fetched_handle, input ready);
    modport sink   (input valid, input key_high, input key_low,
                    input fetched_handle, output ready);
endinterface

// Result channel: one item per lookup.
interface mtflru_result_if
    import mtflru_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;

    modport source (output valid, output hit, output handle_out,
                    output evicted, output evicted_handle, input ready);
    modport sink   (input valid, input hit, input handle_out,
                    input evicted, input evicted_handle, output ready);
endinterface

/* rtl/core/move_to_front_lru_cache.sv */
// Fully associative key cache kept in most-recently-used order, built as a
// row of MAX_ENTRIES cells that each hold one entry and pass it to the next
// cell when the list shifts. A lookup runs through four states: the idle cycle
// in which the item is accepted, one in which every cell compares its key in
// parallel, one in which the cells up to the hit or insert position shift back
// by one, the front cell takes the key and the result is registered, and one
// that presents the result. The next lookup is accepted in the cycle after the
// result is taken, so no new item is accepted while a lookup is in flight.
// A hit returns the stored handle; a miss stores fetched_handle at the front
// and, once the entry count has reached the capacity (clamped to 1 through
// MAX_ENTRIES, 5 after reset), drops the last entry and reports its handle.
// The capacity register may only be written while no lookup is in flight.
module move_to_front_lru_cache
    import mtflru_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    mtflru_lookup_if.sink         lookup,
    mtflru_result_if.source       result
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    entry_t               probe_reg;

    logic                 hit_reg;
    logic [HANDLE_W-1:0]  handle_out_reg;
    logic                 evicted_reg;
    logic [HANDLE_W-1:0]  evicted_handle_reg;

    entry_t               cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;
    cell_ctrl_t           cell_ctrl  [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] seen;

    logic [CW-1:0]        eff_cap;
    logic                 grow;
    logic [CW-1:0]        ins_pos;
    logic                 any_hit;
    logic [HANDLE_W-1:0]  hit_handle;
    logic [HANDLE_W-1:0]  last_handle;
    entry_t               front_entry;
    logic                 accept;

    assign accept = lookup.valid && lookup.ready;

    // Clamp the capacity register to 1 .. MAX_ENTRIES.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(cap_reg) > 32'(MAX_ENTRIES))
        begin
            eff_cap = CW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    // Miss placement: append while below capacity, else reuse the last slot.
    assign grow    = count_reg < eff_cap;
    assign ins_pos = grow ? count_reg : count_reg - CW'(1);

    // Hit and eviction handles gathered from the cells.
    always_comb
    begin
        hit_handle  = '0;
        last_handle = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cell_match[i] && !seen[i])
            begin
                hit_handle = hit_handle | cell_entry[i].handle;
            end
            if (CW'(i + 1) == count_reg)
            begin
                last_handle = last_handle | cell_entry[i].handle;
            end
        end
    end

    assign any_hit = seen[MAX_ENTRIES];

    // New front entry: the probed key with the cached or fetched handle.
    always_comb
    begin
        front_entry        = probe_reg;
        front_entry.handle = any_hit ? hit_handle : probe_reg.handle;
    end

    // Row of cells; seen[i] tells whether a match lies ahead of cell i.
    assign seen[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        entry_t prev_entry;

        assign seen[i + 1] = seen[i] | cell_match[i];

        assign cell_ctrl[i].cmp_en = (state_reg == ST_CMP);
        assign cell_ctrl[i].live   = CW'(i) < count_reg;
        assign cell_ctrl[i].load   = (state_reg == ST_UPD)
                                     && (any_hit ? !seen[i] : (CW'(i) <= ins_pos));

        if (i == 0)
        begin : g_front
            assign prev_entry = front_entry;
        end
        else
        begin : g_back
            assign prev_entry = cell_entry[i - 1];
        end

        mtflru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[i]),
            .probe      (probe_reg),
            .prev_entry (prev_entry),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Entry count grows only on a miss below capacity.
    always_comb
    begin
        count_next = count_reg;
        if ((state_reg == ST_UPD) && !any_hit && grow)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Probe capture and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            probe_reg.key_high <= lookup.key_high;
            probe_reg.key_low  <= lookup.key_low;
            probe_reg.handle   <= lookup.fetched_handle;
        end
        if (state_reg == ST_UPD)
        begin
            hit_reg            <= any_hit;
            handle_out_reg     <= front_entry.handle;
            evicted_reg        <= !any_hit && !grow;
            evicted_handle_reg <= (!any_hit && !grow) ? last_handle : '0;
        end
    end

    assign lookup.ready          = (state_reg == ST_IDLE);
    assign result.valid          = (state_reg == ST_OUT);
    assign result.hit            = hit_reg;
    assign result.handle_out     = handle_out_reg;
    assign result.evicted        = evicted_reg;
    assign result.evicted_handle = evicted_handle_reg;

`ifndef SYNTHESIS
    // A lookup is never taken while a result waits.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !lookup.ready)
        else $error("lookup accepted while a result is pending");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.hit && result.evicted))
        else $error("hit reported together with an eviction");

    // The entry count stays within the row and steps by at most one.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) <= 32'(MAX_ENTRIES))
        && ((count_reg == $past(count_reg))
            || (count_reg == $past(count_reg) + CW'(1))))
        else $error("entry count out of range or jumped");

    // An accepted lookup always starts the compare pass next.
    a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CMP))
        else $error("accepted lookup did not start a compare");
`endif

endmodule

/* rtl/core/mtflru_cell.sv */
// One position of the recency list. It compares its entry against the probe
// key and, when told to, takes the entry of its front neighbor.
module mtflru_cell
    import mtflru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     probe,
    input  entry_t     prev_entry,
    output entry_t     entry,
    output logic       match
);

    entry_t entry_reg;
    logic   match_reg;
    logic   match_next;

    // A match only counts for a live entry; the handle takes no part.
    assign match_next = ctrl.live
                        && (entry_reg.key_high == probe.key_high)
                        && (entry_reg.key_low == probe.key_low);

    // Compare flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= match_next;
        end
    end

    // Entry storage; it moves one place back when loaded.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= prev_entry;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule
